// ===== rtl/wmmmr_pkg.sv =====
// ----------------------------------------------------------------------------
// wmmmr_pkg
// Shared widths, limits and the per-window summary record for the windowed
// min / max / mean / rms statistics block.
// ----------------------------------------------------------------------------
package wmmmr_pkg;

  // field widths
  localparam int SAMPLE_W    = 24;
  localparam int RMS_W       = 23;
  localparam int COUNT_OUT_W = 11;

  // longest window that is accumulated; later samples only flag overflow
  localparam int WINDOW_MAX  = 1024;

  // accumulator widths that follow from the window length
  localparam int POS_W   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W   = SAMPLE_W + POS_W;
  localparam int SQR_W   = 2 * SAMPLE_W;
  localparam int SQ_W    = SQR_W - 1 + POS_W;
  localparam int SQRT_W  = SQ_W + (SQ_W % 2);
  localparam int STEP_W  = $clog2(SQ_W);

  // summary queue between accumulation and the arithmetic engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // sample limits
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [RMS_W-1:0]           RMS_MAX    = {RMS_W{1'b1}};

  // totals of one closed window
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic signed [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]            sq_sum;
    logic [POS_W-1:0]           count;
    logic                       overflow;
  } window_t;

endpackage

// ===== rtl/wmmmr_front.sv =====
// ----------------------------------------------------------------------------
// wmmmr_front
// Sample intake: limit and window-length checks, running min / max / count /
// sum, a registered square and the square-sum accumulator. Pushes one window
// summary into the queue when the closing sample leaves the square stage.
// ----------------------------------------------------------------------------
module wmmmr_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [wmmmr_pkg::SAMPLE_W-1:0]  valid_limit,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [wmmmr_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                   last,
  output logic                                   push,
  output wmmmr_pkg::window_t                     push_data,
  input  logic                                   full
);
  import wmmmr_pkg::*;

  // running window state
  logic [POS_W-1:0]           pos;
  logic [POS_W-1:0]           count;
  logic signed [SAMPLE_W-1:0] running_min;
  logic signed [SAMPLE_W-1:0] running_max;
  logic signed [SUM_W-1:0]    running_sum;
  logic [SQ_W-1:0]            sq_sum;
  logic                       overflow_seen;

  // square stage
  logic                       sq_valid;
  logic                       sq_last;
  logic                       sq_take;
  logic [SQR_W-1:0]           sq;

  logic                       advance;
  logic                       accept;
  logic                       close;
  logic [POS_W-1:0]           pos_base;
  logic [POS_W-1:0]           count_base;
  logic signed [SAMPLE_W-1:0] min_base;
  logic signed [SAMPLE_W-1:0] max_base;
  logic signed [SUM_W-1:0]    sum_base;
  logic                       ovf_base;
  logic                       in_range;
  logic                       take;
  logic signed [SQR_W-1:0]    product;
  logic [SQ_W-1:0]            sq_sum_next;

  // pipeline holds only while a closing sample waits for queue space
  assign advance  = !(sq_valid && sq_last && full);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign close    = sq_valid && sq_last && advance;

  // a sample that follows a closing one starts from a cleared window
  always_comb begin
    if (close) begin
      pos_base   = '0;
      count_base = '0;
      min_base   = SAMPLE_MAX;
      max_base   = SAMPLE_MIN;
      sum_base   = '0;
      ovf_base   = 1'b0;
    end else begin
      pos_base   = pos;
      count_base = count;
      min_base   = running_min;
      max_base   = running_max;
      sum_base   = running_sum;
      ovf_base   = overflow_seen;
    end
  end

  // classification of the incoming sample
  assign in_range = pos_base < POS_W'(WINDOW_MAX);
  assign take     = in_range && (sample < valid_limit);
  assign product  = sample * sample;

  // square-sum including the sample in the square stage
  assign sq_sum_next = sq_sum + (sq_take ? SQ_W'(sq) : '0);

  // summary of the closed window
  always_comb begin
    push               = close;
    push_data.min_v    = running_min;
    push_data.max_v    = running_max;
    push_data.sum      = running_sum;
    push_data.sq_sum   = sq_sum_next;
    push_data.count    = count;
    push_data.overflow = overflow_seen;
  end

  // min / max / count / sum / position, updated at acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      count         <= '0;
      running_min   <= SAMPLE_MAX;
      running_max   <= SAMPLE_MIN;
      running_sum   <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      pos           <= in_range ? pos_base + POS_W'(1) : pos_base;
      overflow_seen <= ovf_base | !in_range;
      if (take) begin
        count       <= count_base + POS_W'(1);
        running_sum <= sum_base + SUM_W'(sample);
        running_min <= (sample < min_base) ? sample : min_base;
        running_max <= (sample > max_base) ? sample : max_base;
      end else begin
        count       <= count_base;
        running_sum <= sum_base;
        running_min <= min_base;
        running_max <= max_base;
      end
    end else if (close) begin
      pos           <= '0;
      count         <= '0;
      running_min   <= SAMPLE_MAX;
      running_max   <= SAMPLE_MIN;
      running_sum   <= '0;
      overflow_seen <= 1'b0;
    end
  end

  // square stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      sq_last  <= 1'b0;
      sq_take  <= 1'b0;
    end else if (advance) begin
      sq_valid <= accept;
      sq_last  <= accept && last;
      sq_take  <= accept && take;
    end
  end

  // square stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sq <= unsigned'(product);
    end
  end

  // square-sum accumulator, cleared as the window closes
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_sum <= '0;
    end else if (advance && sq_valid) begin
      sq_sum <= sq_last ? '0 : sq_sum_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(WINDOW_MAX))
    else $error("window position beyond its limit");
  a_count_within_pos: assert property (@(posedge clk) disable iff (rst)
    count <= pos)
    else $error("counted samples exceed window position");
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (running_min <= running_max))
    else $error("running minimum above running maximum");
`endif

endmodule

// ===== rtl/wmmmr_queue.sv =====
// ----------------------------------------------------------------------------
// wmmmr_queue
// Small fifo of closed-window summaries between sample intake and the
// divide / square-root engine.
// ----------------------------------------------------------------------------
module wmmmr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wmmmr_pkg::window_t push_data,
  output logic               full,
  input  logic               pop,
  output wmmmr_pkg::window_t pop_data,
  output logic               empty
);
  import wmmmr_pkg::*;

  window_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign full     = fill == QFILL_W'(QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QFILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QFILL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/wmmmr_back.sv =====
// ----------------------------------------------------------------------------
// wmmmr_back
// Per-window arithmetic: bit-serial division of the sum and of the square
// sum by the count, then a bit-pair square root of the mean square, and the
// result register toward the output channel.
// ----------------------------------------------------------------------------
module wmmmr_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wmmmr_pkg::window_t                    pop_data,
  input  logic                                  empty,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wmmmr_pkg::SAMPLE_W-1:0] min_value,
  output logic signed [wmmmr_pkg::SAMPLE_W-1:0] max_value,
  output logic signed [wmmmr_pkg::SAMPLE_W-1:0] mean_value,
  output logic [wmmmr_pkg::RMS_W-1:0]           rms_value,
  output logic [wmmmr_pkg::COUNT_OUT_W-1:0]     valid_count,
  output logic                                  no_data,
  output logic                                  window_overflow
);
  import wmmmr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                 state;
  logic [STEP_W-1:0]          step;

  // window being worked on
  logic signed [SAMPLE_W-1:0] w_min;
  logic signed [SAMPLE_W-1:0] w_max;
  logic [POS_W-1:0]           w_count;
  logic                       w_neg;
  logic                       w_nodata;
  logic                       w_ovf;

  // divider registers: quotient shifts in where the dividend shifts out
  logic [SQ_W-1:0]            qm;
  logic [POS_W-1:0]           rm;
  logic [SQ_W-1:0]            qs;
  logic [POS_W-1:0]           rs;

  // square root registers
  logic [SQRT_W-1:0]          sv;
  logic [SQRT_W-1:0]          res;
  logic [SQRT_W-1:0]          bitv;

  logic [SUM_W-1:0]           abs_sum;
  logic [POS_W:0]             r2m;
  logic [POS_W:0]             r2s;
  logic [POS_W:0]             divisor;
  logic                       gem;
  logic                       ges;
  logic [SQ_W-1:0]            qs_next;
  logic [SQRT_W-1:0]          trial;
  logic                       ge_sq;
  logic [SQ_W-1:0]            mean_full;
  logic [RMS_W-1:0]           rms_sat;
  logic                       out_free;

  assign pop      = (state == ST_IDLE) && !empty;
  assign out_free = !out_valid || !out_stall;
  assign abs_sum  = pop_data.sum[SUM_W-1] ? unsigned'(-pop_data.sum)
                                          : unsigned'(pop_data.sum);

  // one restoring step of each divider
  assign divisor = {1'b0, w_count};
  assign r2m     = {rm, qm[SQ_W-1]};
  assign r2s     = {rs, qs[SQ_W-1]};
  assign gem     = r2m >= divisor;
  assign ges     = r2s >= divisor;
  assign qs_next = {qs[SQ_W-2:0], ges};

  // one step of the square root
  assign trial = res + bitv;
  assign ge_sq = sv >= trial;

  // final formatting
  assign mean_full = w_neg ? (~qm + SQ_W'(1)) : qm;
  assign rms_sat   = (res > SQRT_W'(RMS_MAX)) ? RMS_MAX : RMS_W'(res);

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            step  <= STEP_W'(SQ_W - 1);
            state <= (pop_data.count == '0) ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            step  <= STEP_W'(SQRT_W / 2 - 1);
            state <= ST_SQRT;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_SQRT: begin
          if (step == '0) begin
            state <= ST_DONE;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        w_min    <= pop_data.min_v;
        w_max    <= pop_data.max_v;
        w_count  <= pop_data.count;
        w_neg    <= pop_data.sum[SUM_W-1];
        w_nodata <= pop_data.count == '0;
        w_ovf    <= pop_data.overflow;
        qm       <= SQ_W'(abs_sum);
        qs       <= pop_data.sq_sum;
        rm       <= '0;
        rs       <= '0;
        res      <= '0;
      end
      ST_DIV: begin
        qm <= {qm[SQ_W-2:0], gem};
        rm <= gem ? POS_W'(r2m - divisor) : POS_W'(r2m);
        qs <= qs_next;
        rs <= ges ? POS_W'(r2s - divisor) : POS_W'(r2s);
        if (step == '0) begin
          sv   <= SQRT_W'(qs_next);
          res  <= '0;
          bitv <= SQRT_W'(1) << (SQRT_W - 2);
        end
      end
      ST_SQRT: begin
        if (ge_sq) begin
          sv  <= sv - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      min_value       <= w_nodata ? '0 : w_min;
      max_value       <= w_nodata ? '0 : w_max;
      mean_value      <= w_nodata ? '0 : SAMPLE_W'(mean_full);
      rms_value       <= w_nodata ? '0 : rms_sat;
      valid_count     <= COUNT_OUT_W'(w_count);
      no_data         <= w_nodata;
      window_overflow <= w_ovf;
    end
  end

`ifndef SYNTHESIS
  a_divide_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_SQRT) |-> (w_count != '0))
    else $error("division running with a zero count");
  a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> $onehot(bitv))
    else $error("square root trial bit lost");
  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_free) |=> (state == ST_DONE))
    else $error("finished window dropped while output busy");
`endif

endmodule

// ===== rtl/window_min_max_mean_rms_unit.sv =====
// ----------------------------------------------------------------------------
// window_min_max_mean_rms_unit
// Windowed min / max / mean / rms statistics over signed Q16.8 samples.
// ----------------------------------------------------------------------------
// Samples are taken at up to one per cycle; each is checked against
// valid_limit and the window length and folded into running min, max,
// count, sum and square sum (the square passes one register stage). The
// sample flagged last closes the window: its totals go into a two-entry
// queue, and the arithmetic engine produces one result per window, using
// the bit-serial divider (one quotient bit per cycle for the mean and the
// mean square together) followed by the square root (two bits of the
// operand per cycle). Windows with no counted sample skip that work and go
// straight to the result. While both queue entries are full, a closing
// sample holds the intake stalled until the engine frees one. Results sit
// in an output register, so the engine starts the next window while a
// result waits, but holds a finished one until that register is free.
module window_min_max_mean_rms_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic signed [wmmmr_pkg::SAMPLE_W-1:0] cfg_write_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [wmmmr_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wmmmr_pkg::SAMPLE_W-1:0] min_value,
  output logic signed [wmmmr_pkg::SAMPLE_W-1:0] max_value,
  output logic signed [wmmmr_pkg::SAMPLE_W-1:0] mean_value,
  output logic [wmmmr_pkg::RMS_W-1:0]           rms_value,
  output logic [wmmmr_pkg::COUNT_OUT_W-1:0]     valid_count,
  output logic                                  no_data,
  output logic                                  window_overflow
);
  import wmmmr_pkg::*;

  logic signed [SAMPLE_W-1:0] valid_limit;
  logic                       push;
  window_t                    push_data;
  logic                       full;
  logic                       pop;
  window_t                    pop_data;
  logic                       empty;

  // validity limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_limit <= SAMPLE_MAX;
    end else if (cfg_write_en) begin
      valid_limit <= cfg_write_data;
    end
  end

  // sample intake and accumulation
  wmmmr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .valid_limit (valid_limit),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last        (last),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  // closed-window queue
  wmmmr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // divide, square root and result register
  wmmmr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .pop_data        (pop_data),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .min_value       (min_value),
    .max_value       (max_value),
    .mean_value      (mean_value),
    .rms_value       (rms_value),
    .valid_count     (valid_count),
    .no_data         (no_data),
    .window_overflow (window_overflow)
  );

endmodule

// ===== dv/window_min_max_mean_rms_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_min_max_mean_rms_unit_test
// Self-checking bench for the windowed min / max / mean / rms block. Samples
// are sent in windows through the valid / stall channel while results are
// drained with random back-pressure. A scoreboard keeps its own running
// window totals, forms the expected summary on every closing sample and
// checks each result field by field. The validity limit is changed between
// phases, only once the block has drained.
// ----------------------------------------------------------------------------
module window_min_max_mean_rms_unit_test;
  import wmmmr_pkg::*;

  // cycles allowed for the divide / root engine after the last expected result
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASE_ITEMS  = 80;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one window summary as seen on the result port
  typedef struct {
    sample_t                min_v;
    sample_t                max_v;
    sample_t                mean_v;
    logic [RMS_W-1:0]       rms;
    logic [COUNT_OUT_W-1:0] count;
    logic                   no_data;
    logic                   overflow;
  } window_stats_t;

  // ------------------------------------------------------------------------
  // scoreboard: running window totals and the queue of expected summaries
  // ------------------------------------------------------------------------
  class stats_scoreboard;
    sample_t           limit;
    int unsigned       n_counted;
    int unsigned       position;
    longint            lo;
    longint            hi;
    longint            total;
    longint unsigned   sq_total;
    bit                ovf_seen;
    window_stats_t     expected_q[$];
    int                errors;
    int                windows_checked;
    int                samples_noted;

    function new();
      limit = SAMPLE_MAX;
      errors = 0;
      windows_checked = 0;
      samples_noted = 0;
      clear_window();
    endfunction

    function void clear_window();
      n_counted = 0;
      position = 0;
      lo = SAMPLE_MAX;
      hi = SAMPLE_MIN;
      total = 0;
      sq_total = 0;
      ovf_seen = 1'b0;
    endfunction

    function void set_limit(sample_t v);
      limit = v;
    endfunction

    // integer square root, rounded down, one result bit at a time
    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // fold one accepted sample in; a closing sample produces a summary
    function void note_sample(sample_t s, logic is_last);
      window_stats_t   w;
      longint unsigned root;
      samples_noted++;
      if (position < WINDOW_MAX) begin
        position++;
        if (s < limit) begin
          n_counted++;
          total += longint'(s);
          sq_total += longint'(longint'(s) * longint'(s));
          if (longint'(s) < lo) lo = s;
          if (longint'(s) > hi) hi = s;
        end
      end else begin
        ovf_seen = 1'b1;
      end
      if (!is_last) return;
      w.no_data = (n_counted == 0);
      w.overflow = ovf_seen;
      w.count = n_counted[COUNT_OUT_W-1:0];
      if (w.no_data) begin
        w.min_v = '0;
        w.max_v = '0;
        w.mean_v = '0;
        w.rms = '0;
      end else begin
        w.min_v = sample_t'(lo);
        w.max_v = sample_t'(hi);
        w.mean_v = sample_t'(total / longint'(n_counted));
        root = floor_sqrt(sq_total / longint'(n_counted));
        w.rms = (root > RMS_MAX) ? RMS_MAX : root[RMS_W-1:0];
      end
      expected_q.push_back(w);
      clear_window();
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(window_stats_t got);
      window_stats_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no window pending, actual min %0d max %0d count %0d",
                 $time, got.min_v, got.max_v, got.count);
        return;
      end
      want = expected_q.pop_front();
      windows_checked++;
      compare_field("min_value", want.min_v, got.min_v);
      compare_field("max_value", want.max_v, got.max_v);
      compare_field("mean_value", want.mean_v, got.mean_v);
      compare_field("rms_value", want.rms, got.rms);
      compare_field("valid_count", want.count, got.count);
      compare_field("no_data", want.no_data, got.no_data);
      compare_field("window_overflow", want.overflow, got.overflow);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // ------------------------------------------------------------------------
  // signals and the block
  // ------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write_en;
  sample_t                cfg_write_data;
  logic                   in_valid;
  logic                   in_stall;
  sample_t                sample;
  logic                   last;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  sample_t                min_value;
  sample_t                max_value;
  sample_t                mean_value;
  logic [RMS_W-1:0]       rms_value;
  logic [COUNT_OUT_W-1:0] valid_count;
  logic                   no_data;
  logic                   window_overflow;

  stats_scoreboard sb;
  bit              quiet = 1'b0;
  int              out_hold = 0;
  int              limit_settings = 0;

  window_min_max_mean_rms_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .last           (last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .min_value      (min_value),
    .max_value      (max_value),
    .mean_value     (mean_value),
    .rms_value      (rms_value),
    .valid_count    (valid_count),
    .no_data        (no_data),
    .window_overflow(window_overflow)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // result side: random stall, check every accepted transaction
  always @(posedge clk) begin
    window_stats_t got;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.min_v = min_value;
        got.max_v = max_value;
        got.mean_v = mean_value;
        got.rms = rms_value;
        got.count = valid_count;
        got.no_data = no_data;
        got.overflow = window_overflow;
        sb.check_result(got);
        out_hold = draw_wait();
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  // ------------------------------------------------------------------------
  // stimulus tasks
  // ------------------------------------------------------------------------
  task automatic send_sample(input sample_t s, input logic is_last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    last <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s, is_last);
  endtask

  // limit is only changed once every window summary has come back
  task automatic write_limit(input sample_t v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_limit(v);
    limit_settings++;
  endtask

  // mix of full range, small values, values around the limit and extremes
  function automatic sample_t pick_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return sample_t'($urandom);
    if (pick < 7) return sample_t'(int'($urandom_range(0, 2000)) - 1000);
    if (pick < 9) return sb.limit + sample_t'(int'($urandom_range(0, 6)) - 3);
    return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
  endfunction

  function automatic sample_t pick_limit();
    case ($urandom_range(0, 4))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return sample_t'($urandom);
      default: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic int pick_length();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(1, 8);
    if (pick < 19) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    int sent;
    int phase_sent;
    int len;
    sb = new();
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    in_valid <= 1'b0;
    sample <= '0;
    last <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed windows at the widest limit
    write_limit(SAMPLE_MAX);
    send_sample(SAMPLE_MIN, 1'b1);              // root of the most negative square saturates
    send_sample(SAMPLE_MAX, 1'b1);              // not below the limit, so no data
    send_sample(sample_t'(SAMPLE_MAX - 1), 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(1), 1'b1);
    send_sample(sample_t'(-3), 1'b0);           // mean truncates toward zero
    send_sample(sample_t'(-4), 1'b1);
    send_sample(sample_t'(-5), 1'b0);
    send_sample(sample_t'(2), 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);              // mix of counted and dropped samples
    send_sample(sample_t'(7), 1'b1);
    send_sample(sample_t'(256), 1'b0);
    send_sample(sample_t'(512), 1'b0);
    send_sample(sample_t'(768), 1'b1);

    // lowest limit: nothing can count
    write_limit(SAMPLE_MIN);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);

    // limit at zero: only negative samples count
    write_limit('0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample('0, 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(-9), 1'b1);

    // window one sample too long; the closing extreme is dropped
    write_limit(SAMPLE_MAX);
    quiet = 1'b1;
    for (int i = 0; i < WINDOW_MAX; i++) send_sample(pick_sample(), 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    quiet = 1'b0;

    // random phases, each with its own limit
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_limit(pick_limit());
      quiet = ($urandom_range(0, 3) == 0);
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
        len = pick_length();
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
        phase_sent += len;
        sent += len;
      end
    end
    quiet = 1'b0;

    // drain and finish
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d samples under %0d limit settings, %0d window summaries checked",
             sb.samples_noted, limit_settings, sb.windows_checked);
    $display("mismatches: %0d, summaries left over: %0d", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("timeout waiting for the block");
    $display("FAIL");
    $finish;
  end

endmodule
